@@ design/fcdma_pkg.sv @@
`timescale 1ns / 1ps

package fcdma_pkg;

  // Channel count and count widths
  localparam int CHANNELS         = 4;
  localparam int SHORT_COUNT_BITS = 14;
  localparam int LONG_COUNT_BITS  = 16;

  // Fixed field widths
  localparam int CHAN_W = 2;
  localparam int ADDR_W = 32;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 16;
  localparam int CTRL_W = 16;
  localparam int STEP_W = 4;
  localparam int HALF_W = 16;

  localparam logic [ADDR_W-1:0] SRC_LOW_LIMIT = 32'h0200_0000;
  localparam logic [CNT_W-1:0]  SHORT_MASK    =
    CNT_W'((32'd1 << SHORT_COUNT_BITS) - 32'd1);
  localparam logic [CNT_W-1:0]  LONG_MASK     =
    CNT_W'((32'd1 << LONG_COUNT_BITS) - 32'd1);
  localparam logic [CNT_W-1:0]  SOUND_COUNT   = 16'd4;
  localparam logic [CHAN_W-1:0] LONG_CHAN     = 2'd3;
  localparam logic [CHAN_W-1:0] SOUND_CHAN_A  = 2'd1;
  localparam logic [CHAN_W-1:0] SOUND_CHAN_B  = 2'd2;

  // Control word bit positions
  localparam int CTRL_DST_LO    = 5;
  localparam int CTRL_SRC_LO    = 7;
  localparam int CTRL_REPEAT    = 9;
  localparam int CTRL_WORD      = 10;
  localparam int CTRL_TIMING_LO = 12;
  localparam int CTRL_IRQ       = 14;
  localparam int CTRL_ENABLE    = 15;

  typedef enum logic [1:0] {
    FUNC_REG_WRITE   = 2'd0,
    FUNC_START       = 2'd1,
    FUNC_STEP        = 2'd2,
    FUNC_READ_RETURN = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_SRC   = 2'd0,
    REG_DST   = 2'd1,
    REG_COUNT = 2'd2,
    REG_CTRL  = 2'd3
  } reg_sel_t;

  typedef enum logic [1:0] {
    ADJ_INC    = 2'd0,
    ADJ_DEC    = 2'd1,
    ADJ_FIXED  = 2'd2,
    ADJ_RELOAD = 2'd3
  } adj_t;

  typedef enum logic [1:0] {
    TIMING_IMMEDIATE = 2'd0,
    TIMING_VBLANK    = 2'd1,
    TIMING_HBLANK    = 2'd2,
    TIMING_SPECIAL   = 2'd3
  } timing_t;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // Live state of one channel
  typedef struct packed {
    logic [CTRL_W-1:0] ctrl;
    logic [ADDR_W-1:0] src_cur;
    logic [ADDR_W-1:0] dst_cur;
    logic [CNT_W-1:0]  count;
    logic              running;
    logic              sound;
    logic [STEP_W-1:0] src_step;
    logic [STEP_W-1:0] dst_step;
  } chan_state_t;

  // Source address step: fixed and code 3 do not move
  function automatic logic [STEP_W-1:0] src_step_of(input logic word,
                                                    input logic [1:0] adj);
    logic [STEP_W-1:0] s;
    case (adj)
      ADJ_INC: s = word ? 4'd4 : 4'd2;
      ADJ_DEC: s = word ? 4'hC : 4'hE;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  // Destination address step: reload mode advances like increment
  function automatic logic [STEP_W-1:0] dst_step_of(input logic word,
                                                    input logic [1:0] adj);
    logic [STEP_W-1:0] s;
    case (adj)
      ADJ_INC, ADJ_RELOAD: s = word ? 4'd4 : 4'd2;
      ADJ_DEC:             s = word ? 4'hC : 4'hE;
      default:             s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [ADDR_W-1:0] align_mask(input logic word);
    return word ? 32'hFFFF_FFFC : 32'hFFFF_FFFE;
  endfunction

  function automatic logic [ADDR_W-1:0] step_ext(input logic [STEP_W-1:0] s);
    return {{(ADDR_W-STEP_W){s[STEP_W-1]}}, s};
  endfunction

endpackage

@@ design/fcdma_if.sv @@
`timescale 1ns / 1ps

// Input word channel
interface fcdma_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [1:0]  chan;
  logic [1:0]  reg_sel;
  logic [31:0] data;

  modport source(output valid, output func, output chan, output reg_sel,
                 output data, input ready);
  modport sink(input valid, input func, input chan, input reg_sel,
               input data, output ready);
endinterface

// Bus access word channel
interface fcdma_out_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] bus_addr;
  logic        word_size;
  logic [31:0] wdata;
  logic [1:0]  from_chan;
  logic        irq_raise;
  logic [3:0]  run_mask;

  modport source(output valid, output op, output bus_addr, output word_size,
                 output wdata, output from_chan, output irq_raise,
                 output run_mask, input ready);
  modport sink(input valid, input op, input bus_addr, input word_size,
               input wdata, input from_chan, input irq_raise,
               input run_mask, output ready);
endinterface

@@ design/fcdma_finish.sv @@
`timescale 1ns / 1ps

// Close one transfer unit: step the cursors, count down, handle the end.
module fcdma_finish import fcdma_pkg::*; (
  input  chan_state_t       st,
  input  logic [ADDR_W-1:0] dst_base,
  input  logic [CNT_W-1:0]  count_reload,
  input  logic              long_count,
  output chan_state_t       st_nxt,
  output logic              irq
);

  logic [CNT_W-1:0] cnt_mask;
  logic [CNT_W-1:0] cnt_dec;
  logic             rep;
  logic             word;

  assign cnt_mask = long_count ? LONG_MASK : SHORT_MASK;
  assign cnt_dec  = (st.count - 16'd1) & cnt_mask;
  assign rep      = st.ctrl[CTRL_REPEAT];
  assign word     = st.ctrl[CTRL_WORD];

  always_comb begin
    st_nxt         = st;
    irq            = 1'b0;
    st_nxt.src_cur = st.src_cur + step_ext(st.src_step);
    st_nxt.dst_cur = st.dst_cur + step_ext(st.dst_step);
    st_nxt.count   = cnt_dec;
    // End of transfer: stop; a timed repeat reloads, a non-repeat drops the enable
    if (cnt_dec == '0) begin
      st_nxt.running = 1'b0;
      irq            = st.ctrl[CTRL_IRQ];
      if (rep && (st.ctrl[CTRL_TIMING_LO +: 2] != TIMING_IMMEDIATE)) begin
        st_nxt.count = st.sound ? SOUND_COUNT : count_reload;
        if ((st.ctrl[CTRL_DST_LO +: 2] == ADJ_RELOAD) && !st.sound) begin
          st_nxt.dst_cur = dst_base & align_mask(word);
        end
      end else if (!rep) begin
        st_nxt.ctrl[CTRL_ENABLE] = 1'b0;
      end
    end
  end

endmodule

@@ design/four_channel_dma_controller.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// in_if     in         valid / ready      func, chan, reg_sel, data
// out_if    out        valid / ready      op, bus_addr, word_size, wdata,
//                                         from_chan, irq_raise, run_mask
//
// One word is taken per cycle whenever the output register is empty or is
// drained in the same cycle; any bus access it makes appears in the output
// register on the next cycle. Channel selection, address stepping and count
// update are all combinational from the channel registers.
// Reset (rst_n low, synchronous) clears every channel register and the
// pending read. A stalled output holds its word and blocks new input.
module four_channel_dma_controller import fcdma_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  fcdma_in_if.sink     in_if,
  fcdma_out_if.source  out_if
);

  chan_state_t       st_r       [CHANNELS];
  chan_state_t       st_nxt     [CHANNELS];
  logic [ADDR_W-1:0] src_base_r [CHANNELS];
  logic [ADDR_W-1:0] src_base_nxt [CHANNELS];
  logic [ADDR_W-1:0] dst_base_r [CHANNELS];
  logic [ADDR_W-1:0] dst_base_nxt [CHANNELS];
  logic [CNT_W-1:0]  reload_r   [CHANNELS];
  logic [CNT_W-1:0]  reload_nxt [CHANNELS];
  logic [DATA_W-1:0] latch_r    [CHANNELS];
  logic [DATA_W-1:0] latch_nxt  [CHANNELS];
  logic              pending_r;
  logic              pending_nxt;
  logic [CHAN_W-1:0] pchan_r;
  logic [CHAN_W-1:0] pchan_nxt;

  logic              in_accept;
  logic [CHANNELS-1:0] active;
  logic              step_found;
  logic [CHAN_W-1:0] step_sel;
  logic              ret_ok;

  logic [CHAN_W-1:0] fin_chan;
  chan_state_t       fin_st;
  chan_state_t       fin_st_nxt;
  logic [ADDR_W-1:0] fin_dst_base;
  logic [CNT_W-1:0]  fin_reload;
  logic [DATA_W-1:0] fin_latch;
  logic [DATA_W-1:0] fin_wdata;
  logic              fin_irq;
  logic [CTRL_W-1:0] ctrl_val;

  logic              res_valid;
  logic              res_op;
  logic [ADDR_W-1:0] res_addr;
  logic              res_word;
  logic [DATA_W-1:0] res_wdata;
  logic [CHAN_W-1:0] res_chan;
  logic              res_irq;
  logic [3:0]        res_mask;

  logic              out_valid_r;
  logic              out_op_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic              out_word_r;
  logic [DATA_W-1:0] out_wdata_r;
  logic [CHAN_W-1:0] out_chan_r;
  logic              out_irq_r;
  logic [3:0]        out_mask_r;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_accept   = in_if.valid && in_if.ready;
  assign ctrl_val    = in_if.data[CTRL_W-1:0];

  // Pick the lowest-numbered enabled, running channel
  always_comb begin
    step_sel = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      active[i] = st_r[i].ctrl[CTRL_ENABLE] && st_r[i].running;
      if (active[i]) begin
        step_sel = CHAN_W'(i);
      end
    end
  end
  assign step_found = |active;

  // Channel that closes a unit on this word
  assign fin_chan = (in_if.func == FUNC_STEP) ? step_sel : pchan_r;

  always_comb begin
    fin_st       = st_r[0];
    fin_dst_base = dst_base_r[0];
    fin_reload   = reload_r[0];
    fin_latch    = latch_r[0];
    ret_ok       = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (fin_chan == CHAN_W'(i)) begin
        fin_st       = st_r[i];
        fin_dst_base = dst_base_r[i];
        fin_reload   = reload_r[i];
        fin_latch    = latch_r[i];
      end
      if (pchan_r == CHAN_W'(i)) begin
        ret_ok = pending_r && active[i];
      end
    end
  end

  // Write data: open-bus latch on a step, returned data on a read return
  always_comb begin
    if (in_if.func == FUNC_STEP) begin
      if (fin_st.ctrl[CTRL_WORD]) begin
        fin_wdata = fin_latch;
      end else if (fin_st.dst_cur[1]) begin
        fin_wdata = {{HALF_W{1'b0}}, fin_latch[DATA_W-1:HALF_W]};
      end else begin
        fin_wdata = {{HALF_W{1'b0}}, fin_latch[HALF_W-1:0]};
      end
    end else if (fin_st.ctrl[CTRL_WORD]) begin
      fin_wdata = in_if.data;
    end else begin
      fin_wdata = {{HALF_W{1'b0}}, in_if.data[HALF_W-1:0]};
    end
  end

  fcdma_finish u_finish (
    .st           (fin_st),
    .dst_base     (fin_dst_base),
    .count_reload (fin_reload),
    .long_count   (fin_chan == LONG_CHAN),
    .st_nxt       (fin_st_nxt),
    .irq          (fin_irq)
  );

  // Decode the input word and update the channel registers
  always_comb begin
    st_nxt       = st_r;
    src_base_nxt = src_base_r;
    dst_base_nxt = dst_base_r;
    reload_nxt   = reload_r;
    latch_nxt    = latch_r;
    pending_nxt  = pending_r;
    pchan_nxt    = pchan_r;
    res_valid    = 1'b0;
    res_op       = OP_WRITE;
    res_addr     = fin_st.dst_cur;
    res_word     = fin_st.ctrl[CTRL_WORD];
    res_wdata    = fin_wdata;
    res_chan     = fin_chan;
    res_irq      = fin_irq;
    if (in_accept) begin
      unique case (in_if.func)
        FUNC_REG_WRITE: begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (in_if.chan == CHAN_W'(i)) begin
              unique case (in_if.reg_sel)
                REG_SRC:   src_base_nxt[i] = in_if.data;
                REG_DST:   dst_base_nxt[i] = in_if.data;
                REG_COUNT: reload_nxt[i]   = in_if.data[CNT_W-1:0];
                REG_CTRL: begin
                  st_nxt[i].ctrl = ctrl_val;
                  if (!ctrl_val[CTRL_ENABLE]) begin
                    st_nxt[i].running = 1'b0;
                  end else if (!st_r[i].ctrl[CTRL_ENABLE]) begin
                    // Enable rising edge: load cursors and count
                    if ((ctrl_val[CTRL_TIMING_LO +: 2] == TIMING_SPECIAL) &&
                        ((CHAN_W'(i) == SOUND_CHAN_A) ||
                         (CHAN_W'(i) == SOUND_CHAN_B))) begin
                      st_nxt[i].ctrl[CTRL_WORD] = 1'b1;
                      st_nxt[i].count   = SOUND_COUNT;
                      st_nxt[i].src_cur = src_base_r[i] & align_mask(1'b1);
                      st_nxt[i].dst_cur = dst_base_r[i] & align_mask(1'b1);
                      st_nxt[i].sound   = 1'b1;
                    end else begin
                      st_nxt[i].sound   = 1'b0;
                      st_nxt[i].src_cur =
                        src_base_r[i] & align_mask(ctrl_val[CTRL_WORD]);
                      st_nxt[i].dst_cur =
                        dst_base_r[i] & align_mask(ctrl_val[CTRL_WORD]);
                      st_nxt[i].count   = reload_r[i];
                      if (ctrl_val[CTRL_TIMING_LO +: 2] == TIMING_IMMEDIATE) begin
                        st_nxt[i].running  = 1'b1;
                        st_nxt[i].src_step = src_step_of(ctrl_val[CTRL_WORD],
                                                         ctrl_val[CTRL_SRC_LO +: 2]);
                        st_nxt[i].dst_step = dst_step_of(ctrl_val[CTRL_WORD],
                                                         ctrl_val[CTRL_DST_LO +: 2]);
                      end
                    end
                  end
                end
                default: ;
              endcase
            end
          end
        end
        FUNC_START: begin
          for (int i = 0; i < CHANNELS; i++) begin
            if ((in_if.chan == CHAN_W'(i)) && st_r[i].ctrl[CTRL_ENABLE]) begin
              st_nxt[i].running  = 1'b1;
              st_nxt[i].src_step = src_step_of(st_r[i].ctrl[CTRL_WORD],
                                               st_r[i].ctrl[CTRL_SRC_LO +: 2]);
              st_nxt[i].dst_step = st_r[i].sound ? '0 :
                                   dst_step_of(st_r[i].ctrl[CTRL_WORD],
                                               st_r[i].ctrl[CTRL_DST_LO +: 2]);
            end
          end
        end
        FUNC_STEP: begin
          if (!pending_r && step_found) begin
            res_valid = 1'b1;
            if (fin_st.src_cur >= SRC_LOW_LIMIT) begin
              // Issue the read and wait for its data
              pending_nxt = 1'b1;
              pchan_nxt   = step_sel;
              res_op      = OP_READ;
              res_addr    = fin_st.src_cur;
              res_wdata   = '0;
              res_irq     = 1'b0;
            end else begin
              for (int i = 0; i < CHANNELS; i++) begin
                if (step_sel == CHAN_W'(i)) begin
                  st_nxt[i] = fin_st_nxt;
                end
              end
            end
          end
        end
        FUNC_READ_RETURN: begin
          pending_nxt = 1'b0;
          if (ret_ok) begin
            res_valid = 1'b1;
            for (int i = 0; i < CHANNELS; i++) begin
              if (pchan_r == CHAN_W'(i)) begin
                st_nxt[i] = fin_st_nxt;
                if (fin_st.ctrl[CTRL_WORD]) begin
                  latch_nxt[i] = in_if.data;
                end else begin
                  latch_nxt[i] = {in_if.data[HALF_W-1:0], in_if.data[HALF_W-1:0]};
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Run mask after this word
  always_comb begin
    res_mask = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      res_mask[i] = st_nxt[i].ctrl[CTRL_ENABLE] && st_nxt[i].running;
    end
  end

  // Hold channel registers and the output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        st_r[i]       <= '0;
        src_base_r[i] <= '0;
        dst_base_r[i] <= '0;
        reload_r[i]   <= '0;
        latch_r[i]    <= '0;
      end
      pending_r   <= 1'b0;
      pchan_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      src_base_r <= src_base_nxt;
      dst_base_r <= dst_base_nxt;
      reload_r   <= reload_nxt;
      latch_r    <= latch_nxt;
      pending_r  <= pending_nxt;
      pchan_r    <= pchan_nxt;
      if (in_accept && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      out_op_r    <= res_op;
      out_addr_r  <= res_addr;
      out_word_r  <= res_word;
      out_wdata_r <= res_wdata;
      out_chan_r  <= res_chan;
      out_irq_r   <= res_irq;
      out_mask_r  <= res_mask;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.op        = out_op_r;
  assign out_if.bus_addr  = out_addr_r;
  assign out_if.word_size = out_word_r;
  assign out_if.wdata     = out_wdata_r;
  assign out_if.from_chan = out_chan_r;
  assign out_if.irq_raise = out_irq_r;
  assign out_if.run_mask  = out_mask_r;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import fcdma_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  // One input word as queued for the driver
  typedef struct {
    func_t       func;
    logic [1:0]  chan;
    reg_sel_t    sel;
    logic [31:0] data;
    bit          wait_idle;
  } dma_word_t;

  // One bus access as the block should report it
  typedef struct {
    op_t         op;
    logic [31:0] addr;
    logic        word;
    logic [31:0] wdata;
    logic [1:0]  chan;
    logic        irq;
    logic [3:0]  mask;
  } bus_access_t;

  logic clk;
  logic rst_n;

  fcdma_in_if  in_bus ();
  fcdma_out_if out_bus ();

  four_channel_dma_controller u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  dma_word_t   stim_q [$];
  bus_access_t expected_access [$];
  dma_word_t   cur_word;
  bit          hold_next;
  int          total_words;
  int          words_taken;
  int          errors;
  int          cycles;
  int          burst_left;
  int          gap_left;
  int          stall_mode;
  int          stall_left;

  // Channel shadow state
  logic [31:0] ch_src_base [CHANNELS];
  logic [31:0] ch_dst_base [CHANNELS];
  logic [15:0] ch_reload   [CHANNELS];
  logic [15:0] ch_ctrl     [CHANNELS];
  logic [31:0] ch_src_addr [CHANNELS];
  logic [31:0] ch_dst_addr [CHANNELS];
  logic [15:0] ch_left     [CHANNELS];
  logic        ch_busy     [CHANNELS];
  logic        ch_fifo     [CHANNELS];
  logic [3:0]  ch_src_inc  [CHANNELS];
  logic [3:0]  ch_dst_inc  [CHANNELS];
  logic [31:0] ch_latch    [CHANNELS];
  logic        read_out;
  logic [1:0]  read_chan;

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.func    = FUNC_REG_WRITE;
    in_bus.chan    = 2'd0;
    in_bus.reg_sel = REG_SRC;
    in_bus.data    = 32'd0;
    out_bus.ready  = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------

  task automatic clear_channels();
    for (int i = 0; i < CHANNELS; i++) begin
      ch_src_base[i] = '0;
      ch_dst_base[i] = '0;
      ch_reload[i]   = '0;
      ch_ctrl[i]     = '0;
      ch_src_addr[i] = '0;
      ch_dst_addr[i] = '0;
      ch_left[i]     = '0;
      ch_busy[i]     = 1'b0;
      ch_fifo[i]     = 1'b0;
      ch_src_inc[i]  = '0;
      ch_dst_inc[i]  = '0;
      ch_latch[i]    = '0;
    end
    read_out  = 1'b0;
    read_chan = '0;
  endtask

  // Address stride per unit; reload mode moves like increment on the destination only
  function automatic logic [3:0] stride(input logic word, input logic [1:0] adj,
                                        input bit for_dst);
    logic [3:0] s;
    case (adj)
      ADJ_INC:    s = word ? 4'd4 : 4'd2;
      ADJ_DEC:    s = word ? 4'hC : 4'hE;
      ADJ_RELOAD: s = for_dst ? (word ? 4'd4 : 4'd2) : 4'd0;
      default:    s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] unit_align(input logic word);
    return {{30{1'b1}}, ~word, 1'b0};
  endfunction

  function automatic logic is_live(input int c);
    return ch_ctrl[c][CTRL_ENABLE] && ch_busy[c];
  endfunction

  function automatic logic [3:0] live_mask();
    logic [3:0] m;
    m = '0;
    for (int i = 0; i < CHANNELS; i++) m[i] = is_live(i);
    return m;
  endfunction

  task automatic post_access(input op_t op, input logic [31:0] addr, input logic word,
                             input logic [31:0] wd, input int c, input logic irq);
    bus_access_t a;
    a.op    = op;
    a.addr  = addr;
    a.word  = word;
    a.wdata = wd;
    a.chan  = 2'(c);
    a.irq   = irq;
    a.mask  = live_mask();
    expected_access.push_back(a);
  endtask

  // Latch the address strides and mark the channel running
  task automatic launch_channel(input int c);
    logic word;
    word = ch_ctrl[c][CTRL_WORD];
    ch_busy[c]    = 1'b1;
    ch_dst_inc[c] = ch_fifo[c] ? 4'd0 : stride(word, ch_ctrl[c][CTRL_DST_LO +: 2], 1'b1);
    ch_src_inc[c] = stride(word, ch_ctrl[c][CTRL_SRC_LO +: 2], 1'b0);
  endtask

  task automatic load_control(input int c, input logic [15:0] v);
    logic        was_on;
    logic [31:0] keep;
    was_on   = ch_ctrl[c][CTRL_ENABLE];
    ch_ctrl[c] = v;
    if (!v[CTRL_ENABLE]) begin
      ch_busy[c] = 1'b0;
      return;
    end
    if (was_on) return;
    // Enable rising edge: reload cursors and count
    ch_dst_addr[c] = ch_dst_base[c];
    ch_src_addr[c] = ch_src_base[c];
    if (v[CTRL_TIMING_LO +: 2] == TIMING_SPECIAL &&
        (c == SOUND_CHAN_A || c == SOUND_CHAN_B)) begin
      ch_ctrl[c][CTRL_WORD] = 1'b1;
      ch_left[c]            = SOUND_COUNT;
      ch_src_addr[c][1:0]   = 2'b00;
      ch_dst_addr[c][1:0]   = 2'b00;
      ch_fifo[c]            = 1'b1;
    end else begin
      keep           = unit_align(v[CTRL_WORD]);
      ch_fifo[c]     = 1'b0;
      ch_src_addr[c] = ch_src_addr[c] & keep;
      ch_dst_addr[c] = ch_dst_addr[c] & keep;
      ch_left[c]     = ch_reload[c];
      if (v[CTRL_TIMING_LO +: 2] == TIMING_IMMEDIATE) launch_channel(c);
    end
  endtask

  // Write one unit, advance cursors and count, handle end of transfer
  task automatic finish_transfer(input int c, input logic [31:0] wd);
    logic [31:0] addr;
    logic        word;
    logic        irq;
    logic [15:0] lim;
    addr = ch_dst_addr[c];
    word = ch_ctrl[c][CTRL_WORD];
    irq  = 1'b0;
    lim  = (c == LONG_CHAN) ? LONG_MASK : SHORT_MASK;
    ch_src_addr[c] = ch_src_addr[c] + {{28{ch_src_inc[c][3]}}, ch_src_inc[c]};
    ch_dst_addr[c] = ch_dst_addr[c] + {{28{ch_dst_inc[c][3]}}, ch_dst_inc[c]};
    ch_left[c]     = (ch_left[c] - 16'd1) & lim;
    if (ch_left[c] == 16'd0) begin
      ch_busy[c] = 1'b0;
      irq        = ch_ctrl[c][CTRL_IRQ];
      if (ch_ctrl[c][CTRL_REPEAT] &&
          ch_ctrl[c][CTRL_TIMING_LO +: 2] != TIMING_IMMEDIATE) begin
        ch_left[c] = ch_fifo[c] ? SOUND_COUNT : ch_reload[c];
        if (ch_ctrl[c][CTRL_DST_LO +: 2] == ADJ_RELOAD && !ch_fifo[c])
          ch_dst_addr[c] = ch_dst_base[c] & unit_align(word);
      end else if (!ch_ctrl[c][CTRL_REPEAT]) begin
        ch_ctrl[c][CTRL_ENABLE] = 1'b0;
      end
    end
    post_access(OP_WRITE, addr, word, wd, c, irq);
  endtask

  task automatic predict_word(input dma_word_t w);
    int          c;
    bit          served;
    logic [31:0] v;
    c      = w.chan;
    served = 1'b0;
    case (w.func)
      FUNC_REG_WRITE: begin
        case (w.sel)
          REG_SRC:   ch_src_base[c] = w.data;
          REG_DST:   ch_dst_base[c] = w.data;
          REG_COUNT: ch_reload[c]   = w.data[15:0];
          default:   load_control(c, w.data[15:0]);
        endcase
      end
      FUNC_START: begin
        if (ch_ctrl[c][CTRL_ENABLE]) launch_channel(c);
      end
      FUNC_STEP: begin
        // Serve the lowest live channel unless a read is outstanding
        if (!read_out) begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (!served && is_live(i)) begin
              served = 1'b1;
              if (ch_src_addr[i] >= SRC_LOW_LIMIT) begin
                read_out  = 1'b1;
                read_chan = 2'(i);
                post_access(OP_READ, ch_src_addr[i], ch_ctrl[i][CTRL_WORD], 32'd0, i,
                            1'b0);
              end else if (ch_ctrl[i][CTRL_WORD]) begin
                finish_transfer(i, ch_latch[i]);
              end else begin
                v = ch_dst_addr[i][1] ? {16'd0, ch_latch[i][31:16]}
                                      : {16'd0, ch_latch[i][15:0]};
                finish_transfer(i, v);
              end
            end
          end
        end
      end
      default: begin
        // Read data: complete the pending unit, drop it if the channel stopped
        if (read_out) begin
          read_out = 1'b0;
          c        = read_chan;
          if (is_live(c)) begin
            if (ch_ctrl[c][CTRL_WORD]) begin
              ch_latch[c] = w.data;
              finish_transfer(c, w.data);
            end else begin
              ch_latch[c] = {w.data[15:0], w.data[15:0]};
              finish_transfer(c, {16'd0, w.data[15:0]});
            end
          end
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------

  task automatic add_word(input func_t f, input int c, input reg_sel_t s,
                          input logic [31:0] d);
    dma_word_t w;
    w.func      = f;
    w.chan      = 2'(c);
    w.sel       = s;
    w.data      = d;
    w.wait_idle = hold_next;
    hold_next   = 1'b0;
    stim_q.push_back(w);
  endtask

  function automatic logic [15:0] ctrl_word(input bit en, input timing_t t, input adj_t d,
                                            input adj_t s, input bit rep, input bit word,
                                            input bit irq);
    logic [15:0] v;
    v = '0;
    v[CTRL_ENABLE]          = en;
    v[CTRL_TIMING_LO +: 2]  = t;
    v[CTRL_DST_LO +: 2]     = d;
    v[CTRL_SRC_LO +: 2]     = s;
    v[CTRL_REPEAT]          = rep;
    v[CTRL_WORD]            = word;
    v[CTRL_IRQ]             = irq;
    return v;
  endfunction

  task automatic add_disable(input int c);
    logic [31:0] d;
    d = $urandom;
    d[CTRL_ENABLE] = 1'b0;
    add_word(FUNC_REG_WRITE, c, REG_CTRL, d);
  endtask

  task automatic add_noise();
    func_t       f;
    reg_sel_t    s;
    logic [31:0] d;
    f = func_t'($urandom_range(0, 3));
    s = reg_sel_t'($urandom_range(0, 3));
    d = $urandom;
    if (f == FUNC_REG_WRITE && s == REG_CTRL && $urandom_range(0, 1)) d[CTRL_ENABLE] = 1'b0;
    add_word(f, $urandom_range(0, 3), s, d);
  endtask

  // Configure one channel, start it and walk it through its units
  task automatic add_transfer();
    int          c;
    int          n;
    int          units;
    int          k;
    logic [31:0] src;
    logic [31:0] d;
    logic [31:0] cw;
    logic [15:0] cnt;
    bit          sound;
    bit          wipe;
    bit          dropped;
    c = $urandom_range(0, 3);
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       src = 32'h0000_0000;
          1:       src = SRC_LOW_LIMIT - 32'd2;
          2:       src = SRC_LOW_LIMIT;
          default: src = 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3: src = $urandom_range(0, 32'h01FF_FFFF);
      default: src = SRC_LOW_LIMIT + $urandom_range(0, 32'hFDFF_FFFF);
    endcase
    wipe = ($urandom_range(0, 23) == 0);
    n    = $urandom_range(1, 6);
    cnt  = wipe ? 16'd0 : 16'(n);
    if (!wipe && c != LONG_CHAN) cnt[15:14] = 2'($urandom_range(0, 3));
    cw = $urandom;
    cw[CTRL_ENABLE] = 1'b1;

    add_word(FUNC_REG_WRITE, c, REG_SRC, src);
    add_word(FUNC_REG_WRITE, c, REG_DST, $urandom);
    d = $urandom;
    d[15:0] = cnt;
    add_word(FUNC_REG_WRITE, c, REG_COUNT, d);
    if ($urandom_range(0, 3) != 0) add_disable(c);
    add_word(FUNC_REG_WRITE, c, REG_CTRL, cw);

    sound = (c == SOUND_CHAN_A || c == SOUND_CHAN_B) &&
            cw[CTRL_TIMING_LO +: 2] == TIMING_SPECIAL;
    if (cw[CTRL_TIMING_LO +: 2] != TIMING_IMMEDIATE || $urandom_range(0, 3) == 0)
      add_word(FUNC_START, c, reg_sel_t'($urandom_range(0, 3)), $urandom);
    if ($urandom_range(0, 5) == 0)
      add_word(FUNC_START, c, reg_sel_t'($urandom_range(0, 3)), $urandom);

    // Step and return pairs, with the odd missing, late or orphaned return
    units   = wipe ? $urandom_range(2, 6) : (sound ? 4 : n) + $urandom_range(0, 2);
    dropped = 1'b0;
    for (k = 0; k < units && !dropped; k++) begin
      add_word(FUNC_STEP, c, reg_sel_t'($urandom_range(0, 3)), $urandom);
      case ($urandom_range(0, 19))
        0: ;
        1: begin
          add_noise();
          add_word(FUNC_READ_RETURN, c, REG_SRC, $urandom);
        end
        2: begin
          add_disable(c);
          add_word(FUNC_READ_RETURN, c, REG_SRC, $urandom);
          dropped = 1'b1;
        end
        default: add_word(FUNC_READ_RETURN, c, REG_SRC, $urandom);
      endcase
    end

    // Restart a repeating channel for a couple more units
    if (!dropped && cw[CTRL_REPEAT] && cw[CTRL_TIMING_LO +: 2] != TIMING_IMMEDIATE &&
        $urandom_range(0, 1)) begin
      add_word(FUNC_START, c, REG_SRC, $urandom);
      for (k = 0; k < 2; k++) begin
        add_word(FUNC_STEP, c, REG_SRC, $urandom);
        add_word(FUNC_READ_RETURN, c, REG_SRC, $urandom);
      end
    end
    if (wipe || (!dropped && $urandom_range(0, 9) < 6)) add_disable(c);
  endtask

  initial begin : stimulus
    hold_next = 1'b0;

    // Nothing running, nothing pending, trigger on a disabled channel
    add_word(FUNC_STEP, 0, REG_SRC, 32'd0);
    add_word(FUNC_READ_RETURN, 0, REG_SRC, 32'd0);
    add_word(FUNC_START, 0, REG_SRC, 32'd0);

    // Long channel: top source, zero count, halfword, reload dest, repeat
    add_word(FUNC_REG_WRITE, 3, REG_SRC, 32'hFFFF_FFFF);
    add_word(FUNC_REG_WRITE, 3, REG_DST, 32'h0000_0003);
    add_word(FUNC_REG_WRITE, 3, REG_COUNT, 32'hFFFF_0000);
    add_word(FUNC_REG_WRITE, 3, REG_CTRL,
             {16'd0, ctrl_word(1, TIMING_IMMEDIATE, ADJ_RELOAD, ADJ_DEC, 1, 0, 1)});
    add_word(FUNC_STEP, 0, REG_SRC, 32'd0);
    add_word(FUNC_STEP, 0, REG_SRC, 32'd0);
    add_word(FUNC_READ_RETURN, 0, REG_SRC, 32'hDEAD_BEEF);
    add_word(FUNC_STEP, 0, REG_SRC, 32'd0);
    // Stop the channel while its read is outstanding
    add_word(FUNC_REG_WRITE, 3, REG_CTRL,
             {16'd0, ctrl_word(0, TIMING_IMMEDIATE, ADJ_RELOAD, ADJ_DEC, 1, 0, 1)});
    add_word(FUNC_READ_RETURN, 0, REG_SRC, 32'h1234_5678);

    // Sound FIFO channel crossing the open-bus boundary
    add_word(FUNC_REG_WRITE, 1, REG_SRC, 32'h01FF_FFFE);
    add_word(FUNC_REG_WRITE, 1, REG_DST, 32'hFFFF_FFFF);
    add_word(FUNC_REG_WRITE, 1, REG_CTRL,
             {16'd0, ctrl_word(1, TIMING_SPECIAL, ADJ_DEC, ADJ_INC, 1, 0, 1)});
    add_word(FUNC_START, 1, REG_SRC, 32'd0);
    add_word(FUNC_STEP, 0, REG_SRC, 32'd0);
    add_word(FUNC_STEP, 0, REG_SRC, 32'd0);
    add_word(FUNC_READ_RETURN, 0, REG_SRC, 32'hFFFF_FFFF);
    add_word(FUNC_STEP, 0, REG_SRC, 32'd0);
    add_word(FUNC_READ_RETURN, 0, REG_SRC, 32'h0000_0000);
    add_word(FUNC_STEP, 0, REG_SRC, 32'd0);
    add_word(FUNC_READ_RETURN, 0, REG_SRC, 32'hA5A5_5A5A);
    // Enabled channel rewritten with enable still set
    add_word(FUNC_REG_WRITE, 1, REG_CTRL,
             {16'd0, ctrl_word(1, TIMING_SPECIAL, ADJ_INC, ADJ_INC, 0, 1, 0)});

    // Random part, with a full drain before it and once midway
    hold_next = 1'b1;
    while (stim_q.size() < 800) begin
      if ($urandom_range(0, 7) == 0) add_noise();
      else add_transfer();
    end
    hold_next = 1'b1;
    while (stim_q.size() < 1600) begin
      if ($urandom_range(0, 7) == 0) add_noise();
      else add_transfer();
    end
    total_words = stim_q.size();

    do @(negedge clk);
    while (words_taken != total_words || expected_access.size() != 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------
  // Driver: bursts of words with random gaps
  // ---------------------------------------------------------------
  always @(posedge clk) begin : driver
    logic drive;
    if (!rst_n) begin
      clear_channels();
      words_taken = 0;
      burst_left  = 1;
      gap_left    = 0;
      in_bus.valid <= 1'b0;
    end else begin
      drive = in_bus.valid;
      // Predict the word taken at this edge
      if (in_bus.valid && in_bus.ready) begin
        predict_word(cur_word);
        words_taken++;
        drive = 1'b0;
      end
      if (!drive) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() > 0 &&
                     !(stim_q[0].wait_idle && expected_access.size() != 0)) begin
          cur_word = stim_q.pop_front();
          in_bus.func    <= cur_word.func;
          in_bus.chan    <= cur_word.chan;
          in_bus.reg_sel <= cur_word.sel;
          in_bus.data    <= cur_word.data;
          drive = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
      in_bus.valid <= drive;
    end
  end

  // ---------------------------------------------------------------
  // Monitor: compare accesses, stall on a changing pattern
  // ---------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, actual %h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    bus_access_t want;
    logic        rdy;
    if (!rst_n) begin
      errors     = 0;
      stall_mode = 0;
      stall_left = 0;
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_access.size() == 0) begin
          $error("unexpected access: op %0d addr %h chan %0d", out_bus.op,
                 out_bus.bus_addr, out_bus.from_chan);
          errors++;
        end else begin
          want = expected_access.pop_front();
          check_field("op", want.op, out_bus.op);
          check_field("bus_addr", want.addr, out_bus.bus_addr);
          check_field("word_size", want.word, out_bus.word_size);
          check_field("wdata", want.wdata, out_bus.wdata);
          check_field("from_chan", want.chan, out_bus.from_chan);
          check_field("irq_raise", want.irq, out_bus.irq_raise);
          check_field("run_mask", want.mask, out_bus.run_mask);
        end
      end
      // Pick a new stall pattern now and then
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(32, 256);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       rdy = 1'b1;
        1:       rdy = 1'($urandom_range(0, 1));
        2:       rdy = ($urandom_range(0, 3) == 0);
        default: rdy = !out_bus.ready;
      endcase
      out_bus.ready <= rdy;
    end
  end

  // Hard stop on a hang
  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial cycles = 0;

endmodule
